>>> rtl/tcce_pkg.sv
// Package for the text console cursor engine.
// Holds the register file, result item and push bundle types and the code constants.
// No dependencies.
`timescale 1ns / 1ps

package tcce_pkg;

  typedef enum logic [1:0] {
    KIND_UART   = 2'd0,
    KIND_DRAW   = 2'd1,
    KIND_ERASE  = 2'd2,
    KIND_SCROLL = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_FONT_KIND     = 3'd0,
    REG_FONT_WIDTH    = 3'd1,
    REG_FONT_HEIGHT   = 3'd2,
    REG_GLYPH_COUNT   = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5,
    REG_NO_SCROLL     = 3'd6,
    REG_UNUSED        = 3'd7
  } reg_index_t;

  localparam logic       OP_PRINT   = 1'b0;
  localparam logic       OP_PLACE   = 1'b1;
  localparam logic       FONT_FIXED = 1'b0;
  localparam logic       FONT_SIZED = 1'b1;

  localparam logic [7:0] CHAR_BS      = 8'h08;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_ESC     = 8'h1B;
  localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
  localparam logic [7:0] CHAR_RBRACK  = 8'h5D;

  localparam logic [23:0] INK_WHITE   = 24'hFFFFFF;
  localparam logic [2:0]  HEX_DIGITS  = 3'd6;
  localparam int          TAB_STEP    = 8;
  localparam int          FIXED_ADV   = 8;
  localparam int          SCR_BITS    = 13;

  typedef struct packed {
    logic        font_kind;
    logic [5:0]  font_width;
    logic [5:0]  font_height;
    logic [9:0]  glyph_count;
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic        no_scroll;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  uart_byte;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  glyph;
    logic [23:0] ink;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0]       count;
    res_t [2:0]       items;
  } push_t;

endpackage

>>> rtl/text_console_cursor_engine_top.sv
// Top level of the text console cursor engine.
// Instantiates tcce_cfg_regs, tcce_core and tcce_result_queue; depends on tcce_pkg.
//
//   Channel   Direction  Handshake                  Contents
//   s_*       in         s_tvalid / s_tready        console character or place-cursor
//   m_*       out        m_tvalid / m_tready        echo, scroll, draw and erase commands
//   APB       in         psel / penable, pready=1   configuration registers
//
// One input transfer is taken per cycle while s_tready is high; its results are ready in the cycle after.
// Each transfer makes zero to three results, which leave one per cycle, while m_tready
// is high, from a four-entry queue; s_tready is high while that queue holds at most one entry.
// Reset is synchronous and clears the cursor, the escape state, the queue and
// sets the ink to white. The output holds its transfer while m_tready is low.
`timescale 1ns / 1ps

module text_console_cursor_engine_top #(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // char_code[7:0], echo_uart[8], new_x[24:9], new_y[40:25]
  input  logic        s_tuser,   // op[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // uart_byte[7:0], pos_x[23:8], pos_y[39:24], glyph[47:40],
                                 // ink[71:48]
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tcce_pkg::*;

  cfg_t  cfg;
  push_t push;
  res_t  head;
  logic  accept;

  assign accept = s_tvalid && s_tready;

  tcce_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcce_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .in_op     (s_tuser),
    .char_code (s_tdata[7:0]),
    .echo_uart (s_tdata[8]),
    .new_x     (s_tdata[24:9]),
    .new_y     (s_tdata[40:25]),
    .push      (push)
  );

  tcce_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (m_tvalid && m_tready),
    .has_room  (s_tready),
    .not_empty (m_tvalid),
    .head      (head)
  );

  assign m_tdata = {head.ink, head.glyph, head.pos_y, head.pos_x, head.uart_byte};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

>>> rtl/tcce_cfg_regs.sv
// Configuration register file with an APB-style slave port.
// Depends on tcce_pkg for the register layout and index codes.
`timescale 1ns / 1ps

module tcce_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output tcce_pkg::cfg_t    cfg
);
  import tcce_pkg::*;

  reg_index_t index;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign index  = reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.font_kind     <= FONT_SIZED;
      cfg.font_width    <= 6'd7;
      cfg.font_height   <= 6'd14;
      cfg.glyph_count   <= 10'd256;
      cfg.screen_width  <= 13'd1024;
      cfg.screen_height <= 13'd768;
      cfg.no_scroll     <= 1'b0;
    end else if (wr_en) begin
      unique case (index)
        REG_FONT_KIND:     cfg.font_kind     <= pwdata[0];
        REG_FONT_WIDTH:    cfg.font_width    <= pwdata[5:0];
        REG_FONT_HEIGHT:   cfg.font_height   <= pwdata[5:0];
        REG_GLYPH_COUNT:   cfg.glyph_count   <= pwdata[9:0];
        REG_SCREEN_WIDTH:  cfg.screen_width  <= pwdata[12:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= pwdata[12:0];
        REG_NO_SCROLL:     cfg.no_scroll     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_FONT_KIND:     prdata = {31'd0, cfg.font_kind};
      REG_FONT_WIDTH:    prdata = {26'd0, cfg.font_width};
      REG_FONT_HEIGHT:   prdata = {26'd0, cfg.font_height};
      REG_GLYPH_COUNT:   prdata = {22'd0, cfg.glyph_count};
      REG_SCREEN_WIDTH:  prdata = {19'd0, cfg.screen_width};
      REG_SCREEN_HEIGHT: prdata = {19'd0, cfg.screen_height};
      REG_NO_SCROLL:     prdata = {31'd0, cfg.no_scroll};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/tcce_core.sv
// Cursor, ink and escape state with the per-character decode.
// Produces up to three result items per accepted transfer. Depends on tcce_pkg.
`timescale 1ns / 1ps

module tcce_core #(
  parameter int COORD_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  tcce_pkg::cfg_t    cfg,
  input  logic              accept,
  input  logic              in_op,
  input  logic [7:0]        char_code,
  input  logic              echo_uart,
  input  logic [15:0]       new_x,
  input  logic [15:0]       new_y,
  output tcce_pkg::push_t   push
);
  import tcce_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int CMPW = (CB + 1 > SCR_BITS) ? CB + 1 : SCR_BITS;

  logic [CB-1:0] col, col_next, row, row_next;
  logic [23:0]   ink, ink_next;
  logic          esc, esc_next;
  logic [2:0]    hex_count, hex_count_next, hex_count_inc;

  logic [CB-1:0] fw, fh, advance;
  logic [CB:0]   col_plus_fw, row1_plus_fh;
  logic          wrap, scroll;
  logic [CB-1:0] row_plus_fh, row1, col1, row2, col_after, bs_col, tab_col;
  logic          hex_ok;
  logic [3:0]    hex_nib;
  logic [7:0]    glyph;
  logic [1:0]    n;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic res_t uart_item(input logic [7:0] b);
    res_t r;
    r           = '0;
    r.kind      = KIND_UART;
    r.uart_byte = b;
    return r;
  endfunction

  assign fw           = CB'(cfg.font_width);
  assign fh           = CB'(cfg.font_height);
  assign col_plus_fw  = {1'b0, col} + {1'b0, fw};
  assign wrap         = CMPW'(col_plus_fw) >= CMPW'(cfg.screen_width);
  assign row_plus_fh  = row + fh;
  assign row1         = wrap ? row_plus_fh : row;
  assign col1         = wrap ? '0 : col;
  assign row1_plus_fh = {1'b0, row1} + {1'b0, fh};
  assign scroll       = (CMPW'(row1_plus_fh) >= CMPW'(cfg.screen_height)) && !cfg.no_scroll;
  assign row2         = scroll ? ((row1 >= fh) ? row1 - fh : '0) : row1;
  assign advance      = (cfg.font_kind == FONT_FIXED) ? CB'(FIXED_ADV) : fw;
  assign col_after    = col1 + advance;
  assign bs_col       = (col >= fw) ? col - fw : '0;
  assign tab_col      = (col + CB'(TAB_STEP)) & ~CB'(TAB_STEP - 1);
  assign {hex_ok, hex_nib} = hex_decode(char_code);
  assign hex_count_inc = hex_count + 3'd1;
  assign glyph = (cfg.font_kind == FONT_FIXED) ? char_code :
                 ((char_code != 8'd0 && {2'b00, char_code} < cfg.glyph_count) ?
                  char_code : 8'd0);

  always_comb begin
    col_next       = col;
    row_next       = row;
    ink_next       = ink;
    esc_next       = esc;
    hex_count_next = hex_count;
    push           = '0;
    n              = 2'd0;
    if (accept) begin
      if (in_op == OP_PLACE) begin
        col_next = new_x[CB-1:0];
        row_next = new_y[CB-1:0];
      end else if (esc) begin
        ink_next = hex_ok ? {ink[19:0], hex_nib} : INK_WHITE;
        if (echo_uart) begin
          push.items[n] = uart_item(char_code);
          n = n + 2'd1;
        end
        if (hex_count_inc >= HEX_DIGITS) begin
          hex_count_next = 3'd0;
          esc_next       = 1'b0;
          if (echo_uart) begin
            push.items[n] = uart_item(CHAR_RBRACK);
            n = n + 2'd1;
          end
        end else begin
          hex_count_next = hex_count_inc;
        end
      end else begin
        if (echo_uart) begin
          push.items[n] = uart_item(char_code);
          n = n + 2'd1;
        end
        priority if (char_code == CHAR_ESC) begin
          esc_next       = 1'b1;
          hex_count_next = 3'd0;
          if (echo_uart) begin
            push.items[n] = uart_item(CHAR_LBRACK);
            n = n + 2'd1;
          end
        end else if (char_code == CHAR_BS) begin
          if (col != '0) begin
            if (cfg.font_kind == FONT_SIZED) begin
              push.items[n].kind  = KIND_ERASE;
              push.items[n].pos_x = 16'(bs_col);
              push.items[n].pos_y = 16'(row);
              n = n + 2'd1;
            end
            col_next = bs_col;
          end
        end else if (char_code == CHAR_TAB) begin
          col_next = tab_col;
        end else if (char_code == CHAR_CR) begin
          col_next = '0;
        end else if (char_code == CHAR_LF) begin
          col_next = '0;
          row_next = row_plus_fh;
        end else begin
          if (scroll) begin
            push.items[n].kind = KIND_SCROLL;
            n = n + 2'd1;
          end
          push.items[n].kind  = KIND_DRAW;
          push.items[n].pos_x = 16'(col1);
          push.items[n].pos_y = 16'(row2);
          push.items[n].glyph = glyph;
          push.items[n].ink   = ink;
          n = n + 2'd1;
          col_next = col_after;
          row_next = row2;
        end
      end
    end
    if (n != 2'd0) begin
      push.items[n - 2'd1].last = 1'b1;
    end
    push.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      ink       <= INK_WHITE;
      esc       <= 1'b0;
      hex_count <= 3'd0;
    end else begin
      col       <= col_next;
      row       <= row_next;
      ink       <= ink_next;
      esc       <= esc_next;
      hex_count <= hex_count_next;
    end
  end

endmodule

>>> rtl/tcce_result_queue.sv
// Four-entry result queue that takes up to three items in a cycle and gives one.
// Depends on tcce_pkg for the result item and push bundle types.
`timescale 1ns / 1ps

module tcce_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  tcce_pkg::push_t   push,
  input  logic              pop,
  output logic              has_room,
  output logic              not_empty,
  output tcce_pkg::res_t    head
);
  import tcce_pkg::*;

  localparam int DEPTH = 4;

  res_t       entries [DEPTH];
  logic [1:0] wp, rp;
  logic [2:0] count, count_next;

  assign not_empty  = count != 3'd0;
  assign has_room   = count <= 3'(DEPTH - 3);
  assign head       = entries[rp];
  assign count_next = count + 3'(push.count) - 3'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 2'd0;
      rp    <= 2'd0;
      count <= 3'd0;
    end else begin
      wp    <= wp + push.count;
      rp    <= rp + 2'(pop);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push.count) begin
        entries[wp + 2'(i)] <= push.items[i];
      end
    end
  end

endmodule
